>>> hdl/alle_pkg.sv
// Shared types and constants for the array list engine.
// Holds operation codes, fixed stream field widths and the per-cell control struct.
// No dependencies.
package alle_pkg;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REPLACE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RETRIEVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SORT     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STATUS   = 3'd5;

  // Per-cell commands, at most one of which is active in a cycle.
  typedef struct packed {
    logic write;    // load the broadcast write value
    logic shift;    // take the right neighbor's value (gap closing on remove)
    logic pair_lo;  // lower cell of an active compare-exchange pair
    logic pair_hi;  // upper cell of an active compare-exchange pair
  } cell_ctrl_t;

endpackage

>>> hdl/alle_cell.sv
// One storage cell of the array list chain.
// Depends on alle_pkg for the cell control struct.
module alle_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  alle_pkg::cell_ctrl_t  ctrl,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] left_value,
  input  logic [DATA_WIDTH-1:0] right_value,
  input  logic                  left_gt,
  output logic [DATA_WIDTH-1:0] value,
  output logic                  gt
);

  logic [DATA_WIDTH-1:0] value_next;

  // Signed order: this entry is greater than its right neighbor.
  assign gt = $signed(value) > $signed(right_value);

  always_comb begin
    value_next = value;
    if (ctrl.write) begin
      value_next = wdata;
    end else if (ctrl.shift) begin
      value_next = right_value;
    end else if (ctrl.pair_lo && gt) begin
      value_next = right_value;
    end else if (ctrl.pair_hi && left_gt) begin
      value_next = left_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> hdl/array_list_engine_top.sv
// Array list engine: an ordered list of up to DEPTH signed entries held in a chain of cells.
// Results are registered into the output stage, or into the skid slot while one waits.
// Throughput: one request per cycle while the skid slot is empty; a sort of two or more
// entries holds off requests, running one odd-even chain compare-exchange step per cycle.
// Reset (rst, synchronous) clears the count, the sorter and the output stages; entry
// contents are not reset and are never read before being written.
module array_list_engine_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata fields, low bit first: position[3:0], new_value[35:4], zero pad [39:36].
  input  logic [39:0] s_tdata,
  // s_tuser fields: kind[2:0].
  input  logic [2:0]  s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // m_tdata fields, low bit first: read_value[31:0], ok[32], count[37:33],
  // empty_res[38], zero pad [39].
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PW  = (CW > alle_pkg::POS_W) ? CW : alle_pkg::POS_W;
  localparam int RW  = alle_pkg::VALUE_W + 1 + alle_pkg::COUNT_W + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SORT = 1'b1;

  // Request fields.
  logic [alle_pkg::KIND_W-1:0]  kind;
  logic [alle_pkg::POS_W-1:0]   position;
  logic [alle_pkg::VALUE_W-1:0] new_value;

  assign kind      = s_tuser;
  assign position  = s_tdata[alle_pkg::POS_W-1:0];
  assign new_value = s_tdata[alle_pkg::POS_W +: alle_pkg::VALUE_W];

  // Control state.
  logic          state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] phase;

  // Output register plus a skid slot, so a request can be taken while a result waits.
  logic          out_valid;
  logic [RW-1:0] out_data;
  logic          skid_valid;
  logic [RW-1:0] skid_data;

  logic accept;
  logic take;
  logic sorting;

  assign s_tready = (state == ST_IDLE) && !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = out_valid && m_tready;
  assign sorting  = (state == ST_SORT);

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

  // Widened comparisons between the 4-bit position and the count.
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic          pos_ok;
  logic          not_full;

  assign pos_ext  = PW'(position);
  assign cnt_ext  = PW'(count);
  assign pos_ok   = pos_ext < cnt_ext;
  assign not_full = count < CW'(DEPTH);

  // Write value kept in its low DATA_WIDTH bits.
  logic [DATA_WIDTH-1:0] wdata;

  generate
    if (DATA_WIDTH <= alle_pkg::VALUE_W) begin : g_wnarrow
      assign wdata = new_value[DATA_WIDTH-1:0];
    end else begin : g_wwide
      assign wdata = {{(DATA_WIDTH - alle_pkg::VALUE_W){1'b0}}, new_value};
    end
  endgenerate

  // Cell chain.
  logic [DATA_WIDTH-1:0] value [DEPTH];
  logic [DEPTH-1:0]      gt;
  alle_pkg::cell_ctrl_t  ctrl  [DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic at_pos;
      logic from_pos;
      logic has_right;

      assign at_pos    = pos_ext == PW'(gi);
      assign from_pos  = pos_ext <= PW'(gi);
      assign has_right = CW'(gi + 1) < count;

      // Insert lands in the first free cell; replace overwrites the addressed one.
      assign ctrl[gi].write = accept &&
          (((kind == alle_pkg::KIND_INSERT) && not_full && (CW'(gi) == count)) ||
           ((kind == alle_pkg::KIND_REPLACE) && pos_ok && at_pos));
      // Remove shifts every later entry down by one cell.
      assign ctrl[gi].shift = accept && (kind == alle_pkg::KIND_REMOVE) && pos_ok &&
                              from_pos && has_right;
      // Odd-even transposition: even phases pair (0,1),(2,3)..., odd phases (1,2),(3,4)...
      assign ctrl[gi].pair_lo = sorting && (1'(gi % 2) == phase[0]) && has_right;

      if (gi == 0) begin : g_first
        assign ctrl[gi].pair_hi = 1'b0;
        alle_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
          .clk        (clk),
          .ctrl       (ctrl[gi]),
          .wdata      (wdata),
          .left_value (value[gi]),
          .right_value(value[gi + 1]),
          .left_gt    (1'b0),
          .value      (value[gi]),
          .gt         (gt[gi])
        );
      end else begin : g_rest
        logic in_list;

        assign in_list = CW'(gi) < count;
        assign ctrl[gi].pair_hi = sorting && (1'((gi - 1) % 2) == phase[0]) && in_list;
        alle_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
          .clk        (clk),
          .ctrl       (ctrl[gi]),
          .wdata      (wdata),
          .left_value (value[gi - 1]),
          .right_value(value[(gi == DEPTH - 1) ? gi : gi + 1]),
          .left_gt    (gt[gi - 1]),
          .value      (value[gi]),
          .gt         (gt[gi])
        );
      end
    end
  endgenerate

  // Read port: the cell at the requested position, gathered by an AND-OR select.
  logic [DATA_WIDTH-1:0] read_sel;

  always_comb begin
    read_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_ext == PW'(i)) begin
        read_sel = read_sel | value[i];
      end
    end
  end

  logic [alle_pkg::VALUE_W-1:0] read_ext;

  generate
    if (DATA_WIDTH >= alle_pkg::VALUE_W) begin : g_rnarrow
      assign read_ext = read_sel[alle_pkg::VALUE_W-1:0];
    end else begin : g_rwide
      assign read_ext = {{(alle_pkg::VALUE_W - DATA_WIDTH){read_sel[DATA_WIDTH-1]}},
                         read_sel};
    end
  endgenerate

  // Result of the request being accepted. A sort reports at once, since it never changes
  // the count or fails; the chain finishes the reordering before the next request.
  logic                         res_ok;
  logic [alle_pkg::VALUE_W-1:0] res_read;
  logic [RW-1:0]                res_data;

  always_comb begin
    res_ok     = 1'b0;
    res_read   = '0;
    count_next = count;
    case (kind)
      alle_pkg::KIND_INSERT: begin
        if (not_full) begin
          res_ok     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      alle_pkg::KIND_REPLACE: begin
        res_ok = pos_ok;
      end
      alle_pkg::KIND_REMOVE: begin
        if (pos_ok) begin
          res_ok     = 1'b1;
          res_read   = read_ext;
          count_next = count - CW'(1);
        end
      end
      alle_pkg::KIND_RETRIEVE: begin
        if (pos_ok) begin
          res_ok   = 1'b1;
          res_read = read_ext;
        end
      end
      alle_pkg::KIND_SORT: begin
        res_ok = 1'b1;
      end
      alle_pkg::KIND_STATUS: begin
        res_ok = 1'b1;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign res_data = {(count_next == '0), alle_pkg::COUNT_W'(count_next), res_ok, res_read};

  // Count and sort sequencer. A sort of two or more entries runs count phases.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      phase <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= count_next;
            if ((kind == alle_pkg::KIND_SORT) && (count > CW'(1))) begin
              state <= ST_SORT;
              phase <= '0;
            end
          end
        end
        ST_SORT: begin
          phase <= phase + CW'(1);
          if (phase == count - CW'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register and skid slot. A request is only taken with the skid slot empty,
  // so a skid move and a new result never meet in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take && skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (accept && (!out_valid || take)) begin
        out_data <= res_data;
      end
      if (accept && out_valid && !take) begin
        skid_data  <= res_data;
        skid_valid <= 1'b1;
      end
      if (take && !skid_valid) begin
        out_valid <= accept;
      end else if (accept) begin
        out_valid <= 1'b1;
      end
    end
  end

endmodule
